// ----- sv/emt_pkg.sv -----
// emt_pkg: shared types and constants for the encoder multiturn tracker
// used by every module of the block; depends on nothing
`default_nettype none

package emt_pkg;

    localparam int MOTORS_PER_BUS_DEF  = 8;
    localparam int COUNTS_PER_TURN_DEF = 8192;

    localparam int ANGLE_W    = 13;
    localparam int ID_W       = 11;
    localparam int LEN_W      = 4;
    localparam int SPEED_W    = 16;
    localparam int TURN_W     = 16;
    localparam int INDEX_W    = 3;
    localparam int POS_W      = 30;
    localparam int SLOT_W_MAX = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_WINDOW   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_FRAME_ID = 1'd1;

    localparam logic [ANGLE_W-1:0] WRAP_WINDOW_RST   = 13'd1000;
    localparam logic [ID_W-1:0]    BASE_FRAME_ID_RST = 11'h201;

    localparam logic [LEN_W-1:0] FULL_FRAME_LEN = 4'd8;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                      hit;
        logic                      bus;
        logic [SLOT_W_MAX-1:0]     slot;
        logic [ANGLE_W-1:0]        angle;
        logic signed [SPEED_W-1:0] speed;
    } t_work;

endpackage

`default_nettype wire

// ----- sv/emt_front.sv -----
// emt_front: accepts feedback frames and classifies them into work beats
// depends on emt_pkg
`default_nettype none

module emt_front #(
    parameter int MOTORS_PER_BUS = emt_pkg::MOTORS_PER_BUS_DEF
) (
    input  wire logic                               i_valid,
    input  wire logic                               i_full,
    input  wire logic                               i_bus_select,
    input  wire logic [emt_pkg::ID_W-1:0]           i_frame_id,
    input  wire logic                               i_is_standard,
    input  wire logic [emt_pkg::LEN_W-1:0]          i_frame_length,
    input  wire logic [emt_pkg::ANGLE_W-1:0]        i_angle_raw,
    input  wire logic signed [emt_pkg::SPEED_W-1:0] i_motor_speed,
    input  wire logic [emt_pkg::ID_W-1:0]           i_base_frame_id,
    output emt_pkg::t_work                          o_work,
    output logic                                    o_push,
    output logic                                    o_stall
);

    logic [emt_pkg::ID_W:0] diff;
    logic                   in_range;
    logic                   bus_ok;

    assign diff     = {1'b0, i_frame_id} - {1'b0, i_base_frame_id};
    assign in_range = !diff[emt_pkg::ID_W]
                      && (diff[emt_pkg::ID_W-1:0] < emt_pkg::ID_W'(MOTORS_PER_BUS));
    assign bus_ok   = !i_bus_select
                      || (i_is_standard && (i_frame_length == emt_pkg::FULL_FRAME_LEN));

    always_comb begin
        o_work.hit   = in_range && bus_ok;
        o_work.bus   = i_bus_select;
        o_work.slot  = diff[emt_pkg::SLOT_W_MAX-1:0];
        o_work.angle = i_angle_raw;
        o_work.speed = i_motor_speed;
    end

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

endmodule

`default_nettype wire

// ----- sv/emt_queue.sv -----
// emt_queue: short queue of work beats between front and back
// depends on emt_pkg
`default_nettype none

module emt_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire emt_pkg::t_work i_work,
    input  wire logic           i_pop,
    output emt_pkg::t_work      o_work,
    output logic                o_avail,
    output logic                o_full
);

    localparam int PTR_W = $clog2(emt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(emt_pkg::QUEUE_DEPTH + 1);

    emt_pkg::t_work   r_mem [emt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, n_wp;
    logic [PTR_W-1:0] r_rp, n_rp;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_pop;

    assign o_avail = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_W'(emt_pkg::QUEUE_DEPTH));
    assign o_work  = r_mem[r_rp];
    assign do_pop  = i_pop && o_avail;

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wp = (r_wp == PTR_W'(emt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PTR_W'(emt_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_work;
        end
    end

endmodule

`default_nettype wire

// ----- sv/emt_back.sv -----
// emt_back: per-motor turn state, wrap detection and the output register
// depends on emt_pkg
`default_nettype none

module emt_back #(
    parameter int MOTORS_PER_BUS  = emt_pkg::MOTORS_PER_BUS_DEF,
    parameter int COUNTS_PER_TURN = emt_pkg::COUNTS_PER_TURN_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire emt_pkg::t_work                     i_work,
    input  wire logic                               i_avail,
    output logic                                    o_pop,
    input  wire logic [emt_pkg::ANGLE_W-1:0]        i_wrap_window,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic                                    o_motor_hit,
    output logic [emt_pkg::INDEX_W-1:0]             o_motor_index,
    output logic signed [emt_pkg::TURN_W-1:0]       o_gated_turns,
    output logic signed [emt_pkg::TURN_W-1:0]       o_simple_turns,
    output logic signed [emt_pkg::POS_W-1:0]        o_multiturn_position
);

    localparam int SW    = (MOTORS_PER_BUS > 1) ? $clog2(MOTORS_PER_BUS) : 1;
    localparam int GI_W  = $clog2(2 * MOTORS_PER_BUS);
    localparam int CPT_W = $clog2(COUNTS_PER_TURN + 1);
    localparam int HI_W  = ((CPT_W > emt_pkg::ANGLE_W) ? CPT_W : emt_pkg::ANGLE_W) + 1;
    localparam logic signed [emt_pkg::POS_W-1:0] TURN_P = emt_pkg::POS_W'(COUNTS_PER_TURN);

    logic [emt_pkg::ANGLE_W-1:0] r_g_angle [2*MOTORS_PER_BUS];
    logic [emt_pkg::TURN_W-1:0]  r_g_count [2*MOTORS_PER_BUS];
    logic [emt_pkg::ANGLE_W-1:0] r_s_angle [MOTORS_PER_BUS];
    logic [emt_pkg::TURN_W-1:0]  r_s_count [MOTORS_PER_BUS];

    logic                                r_valid;
    logic                                r_hit;
    logic [emt_pkg::INDEX_W-1:0]         r_index;
    logic [emt_pkg::TURN_W-1:0]          r_gated;
    logic [emt_pkg::TURN_W-1:0]          r_simple;
    logic [emt_pkg::POS_W-1:0]           r_pos;

    logic [SW-1:0]                       slot;
    logic [GI_W-1:0]                     gidx;
    logic                                go;
    logic signed [HI_W-1:0]              hi;
    logic signed [HI_W-1:0]              n_ext;
    logic signed [HI_W-1:0]              g_old_ext;
    logic signed [HI_W-1:0]              s_old_ext;
    logic                                n_low;
    logic                                n_high;
    logic                                sp_pos;
    logic                                sp_neg;
    logic                                g_up, g_dn, s_up, s_dn;
    logic [emt_pkg::TURN_W-1:0]          g_cnt, s_cnt;
    logic [emt_pkg::TURN_W-1:0]          n_gated, n_simple;
    logic signed [emt_pkg::POS_W-1:0]    s_ext;
    logic [emt_pkg::POS_W-1:0]           n_pos;

    assign go    = i_avail && (!r_valid || !i_stall);
    assign o_pop = go;

    assign slot = i_work.slot[SW-1:0];
    assign gidx = GI_W'(slot) + (i_work.bus ? GI_W'(MOTORS_PER_BUS) : '0);

    assign hi        = HI_W'(COUNTS_PER_TURN) - HI_W'(i_wrap_window);
    assign n_ext     = HI_W'(i_work.angle);
    assign g_old_ext = HI_W'(r_g_angle[gidx]);
    assign s_old_ext = HI_W'(r_s_angle[slot]);
    assign n_low     = i_work.angle < i_wrap_window;
    assign n_high    = n_ext > hi;
    assign sp_pos    = !i_work.speed[emt_pkg::SPEED_W-1] && (i_work.speed != '0);
    assign sp_neg    = i_work.speed[emt_pkg::SPEED_W-1];

    assign g_up = n_low && (g_old_ext > hi) && sp_pos;
    assign g_dn = n_high && (r_g_angle[gidx] < i_wrap_window) && sp_neg;
    assign s_up = n_low && (s_old_ext > hi);
    assign s_dn = n_high && (r_s_angle[slot] < i_wrap_window);

    always_comb begin
        g_cnt = r_g_count[gidx];
        s_cnt = r_s_count[slot];
        priority if (g_up) begin
            n_gated = g_cnt + 1'b1;
        end else if (g_dn) begin
            n_gated = g_cnt - 1'b1;
        end else begin
            n_gated = g_cnt;
        end
        priority if (s_up) begin
            n_simple = s_cnt + 1'b1;
        end else if (s_dn) begin
            n_simple = s_cnt - 1'b1;
        end else begin
            n_simple = s_cnt;
        end
        s_ext = emt_pkg::POS_W'(signed'(n_simple));
        n_pos = emt_pkg::POS_W'(i_work.angle) + emt_pkg::POS_W'(s_ext * TURN_P);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 2 * MOTORS_PER_BUS; i++) begin
                r_g_angle[i] <= '0;
                r_g_count[i] <= '0;
            end
            for (int i = 0; i < MOTORS_PER_BUS; i++) begin
                r_s_angle[i] <= '0;
                r_s_count[i] <= '0;
            end
        end else if (go && i_work.hit) begin
            r_g_angle[gidx] <= i_work.angle;
            r_g_count[gidx] <= n_gated;
            if (i_work.bus) begin
                r_s_angle[slot] <= i_work.angle;
                r_s_count[slot] <= n_simple;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (go) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go) begin
            r_hit <= i_work.hit;
            if (i_work.hit) begin
                r_index  <= i_work.slot[emt_pkg::INDEX_W-1:0];
                r_gated  <= n_gated;
                r_simple <= i_work.bus ? n_simple : '0;
                r_pos    <= i_work.bus ? n_pos : emt_pkg::POS_W'(i_work.angle);
            end else begin
                r_index  <= '0;
                r_gated  <= '0;
                r_simple <= '0;
                r_pos    <= '0;
            end
        end
    end

    assign o_valid              = r_valid;
    assign o_motor_hit          = r_hit;
    assign o_motor_index        = r_index;
    assign o_gated_turns        = r_gated;
    assign o_simple_turns       = r_simple;
    assign o_multiturn_position = r_pos;

endmodule

`default_nettype wire

// ----- sv/encoder_multiturn_tracker_top.sv -----
// encoder_multiturn_tracker_top: front classify, 2-entry queue, back update+register
// one frame per cycle unless stalled; a beat is held in queue, then output register
// state read, wrap check and write back of a motor entry happen in the same back cycle
// synchronous active-low reset clears all turn counts and angles, the queue and the
// output valid, and loads wrap_window 1000 and base_frame_id 0x201
// depends on emt_pkg, emt_front, emt_queue, emt_back
`default_nettype none

module encoder_multiturn_tracker_top #(
    parameter int MOTORS_PER_BUS  = emt_pkg::MOTORS_PER_BUS_DEF,
    parameter int COUNTS_PER_TURN = emt_pkg::COUNTS_PER_TURN_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [emt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [emt_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic                               i_bus_select,
    input  wire logic [emt_pkg::ID_W-1:0]           i_frame_id,
    input  wire logic                               i_is_standard,
    input  wire logic [emt_pkg::LEN_W-1:0]          i_frame_length,
    input  wire logic [emt_pkg::ANGLE_W-1:0]        i_angle_raw,
    input  wire logic signed [emt_pkg::SPEED_W-1:0] i_motor_speed,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic                                    o_motor_hit,
    output logic [emt_pkg::INDEX_W-1:0]             o_motor_index,
    output logic signed [emt_pkg::TURN_W-1:0]       o_gated_turns,
    output logic signed [emt_pkg::TURN_W-1:0]       o_simple_turns,
    output logic signed [emt_pkg::POS_W-1:0]        o_multiturn_position
);

    logic [emt_pkg::ANGLE_W-1:0] r_wrap_window;
    logic [emt_pkg::ID_W-1:0]    r_base_frame_id;

    emt_pkg::t_work front_work;
    emt_pkg::t_work queue_work;
    logic           push;
    logic           pop;
    logic           avail;
    logic           full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_window   <= emt_pkg::WRAP_WINDOW_RST;
            r_base_frame_id <= emt_pkg::BASE_FRAME_ID_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                emt_pkg::CFG_WRAP_WINDOW: begin
                    r_wrap_window <= i_cfg_data;
                end
                emt_pkg::CFG_BASE_FRAME_ID: begin
                    r_base_frame_id <= i_cfg_data[emt_pkg::ID_W-1:0];
                end
            endcase
        end
    end

    emt_front #(
        .MOTORS_PER_BUS (MOTORS_PER_BUS)
    ) u_front (
        .i_valid         (i_in_valid),
        .i_full          (full),
        .i_bus_select    (i_bus_select),
        .i_frame_id      (i_frame_id),
        .i_is_standard   (i_is_standard),
        .i_frame_length  (i_frame_length),
        .i_angle_raw     (i_angle_raw),
        .i_motor_speed   (i_motor_speed),
        .i_base_frame_id (r_base_frame_id),
        .o_work          (front_work),
        .o_push          (push),
        .o_stall         (o_in_stall)
    );

    emt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_work  (front_work),
        .i_pop   (pop),
        .o_work  (queue_work),
        .o_avail (avail),
        .o_full  (full)
    );

    emt_back #(
        .MOTORS_PER_BUS  (MOTORS_PER_BUS),
        .COUNTS_PER_TURN (COUNTS_PER_TURN)
    ) u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_work               (queue_work),
        .i_avail              (avail),
        .o_pop                (pop),
        .i_wrap_window        (r_wrap_window),
        .o_valid              (o_out_valid),
        .i_stall              (i_out_stall),
        .o_motor_hit          (o_motor_hit),
        .o_motor_index        (o_motor_index),
        .o_gated_turns        (o_gated_turns),
        .o_simple_turns       (o_simple_turns),
        .o_multiturn_position (o_multiturn_position)
    );

endmodule

`default_nettype wire

// ----- sv/emt_checker.sv -----
// emt_checker: port-level assertions for the tracker, bound to the top level
// depends on emt_pkg and encoder_multiturn_tracker_top
`default_nettype none

module emt_checker (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               o_out_valid,
    input wire logic                               i_out_stall,
    input wire logic                               o_motor_hit,
    input wire logic [emt_pkg::INDEX_W-1:0]        o_motor_index,
    input wire logic signed [emt_pkg::TURN_W-1:0]  o_gated_turns,
    input wire logic signed [emt_pkg::TURN_W-1:0]  o_simple_turns,
    input wire logic signed [emt_pkg::POS_W-1:0]   o_multiturn_position
);

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid after reset");

    a_valid_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled output beat dropped");

    a_miss_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_motor_hit |->
            o_motor_index == '0 && o_gated_turns == '0 && o_simple_turns == '0
            && o_multiturn_position == '0)
        else $error("missed frame has nonzero result");

    a_pos_is_angle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_simple_turns == '0 |->
            o_multiturn_position[emt_pkg::POS_W-1:emt_pkg::ANGLE_W] == '0)
        else $error("position above one turn with zero simple count");

endmodule

bind encoder_multiturn_tracker_top emt_checker u_emt_checker (
    .i_clk                (i_clk),
    .i_rst_n              (i_rst_n),
    .o_out_valid          (o_out_valid),
    .i_out_stall          (i_out_stall),
    .o_motor_hit          (o_motor_hit),
    .o_motor_index        (o_motor_index),
    .o_gated_turns        (o_gated_turns),
    .o_simple_turns       (o_simple_turns),
    .o_multiturn_position (o_multiturn_position)
);

`default_nettype wire
